FILE: src/mms_pkg.sv
// Shared types and constants of the streaming matrix multiply block.
// No dependencies; the other files of the block, but for mms_in_if, refer to it by scoped names.
package mms_pkg;

  // Fixed field widths of the channels and the register port
  localparam int ACC_W      = 36;
  localparam int COL_IDX_W  = 4;
  localparam int ROWS_W     = 16;
  localparam int SIZE_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register reset values
  localparam logic [ROWS_W-1:0] ROWS_RESET = 16'd1;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT  = 2'd0,
    REG_INNER_SIZE = 2'd1,
    REG_COL_COUNT  = 2'd2
  } cfg_reg_e;

  // Input command codes
  typedef enum logic {
    CMD_WEIGHT = 1'b0,
    CMD_ACTIV  = 1'b1
  } cmd_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_FLUSH,
    ST_DRAIN
  } state_e;

  // Sequencer to weight feed
  typedef struct packed {
    logic wr_en;
    logic load_a;
    logic issue;
  } feed_cmd_t;

  // Sequencer to every accumulator cell
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage

FILE: src/mms_in_if.sv
// Input channel of the matrix multiply block: valid/ready plus a command bit and one element.
// Depends on nothing; the element width is set per instance.
interface mms_in_if #(
  parameter int ElemW = 16
);
  logic             valid;
  logic             ready;
  logic             command;
  logic [ElemW-1:0] element_value;

  modport source (output valid, output command, output element_value, input ready);
  modport sink   (input valid, input command, input element_value, output ready);
endinterface

FILE: src/mms_out_if.sv
// Output channel of the matrix multiply block: valid/ready plus one result.
// Depends on mms_pkg for the result field widths.
interface mms_out_if;
  logic                                valid;
  logic                                ready;
  logic [mms_pkg::COL_IDX_W-1:0]       col_index;
  logic signed [mms_pkg::ACC_W-1:0]    product_value;
  logic                                last_of_row;
  logic                                last_of_matrix;

  modport source (output valid, output col_index, output product_value,
                  output last_of_row, output last_of_matrix, input ready);
  modport sink   (input valid, input col_index, input product_value,
                  input last_of_row, input last_of_matrix, output ready);
endinterface

FILE: src/matrix_multiply_stream_core.sv
// Streaming fixed-point matrix multiply C = A x B. B elements (command 0) are
// written row-major into the weight store as they are accepted. An A element
// (command 1) reads its B row through the single store read port and
// multiplier, then waits for the last product to travel down the accumulator
// chain to its cell. The element that ends a row of A then shifts the results
// out of the chain head, one per column, and waits while the output stalls.
// After reset every entry of the store is cleared before the first item is
// taken; register writes are taken at any time the block is idle.
module matrix_multiply_stream_core #(
  parameter int MAX_INNER     = 16,
  parameter int MAX_COLS      = 16,
  parameter int ELEMENT_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mms_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mms_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  mms_in_if.sink                            in_ch,
  mms_out_if.source                         out_ch
);

  localparam int DEPTH    = MAX_INNER * MAX_COLS;
  localparam int SA_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TAG_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int K_W      = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int INNER_CW = $clog2(MAX_INNER + 1);
  localparam int COL_CW   = $clog2(MAX_COLS + 1);

  // Registers
  logic [mms_pkg::ROWS_W-1:0] rows_q;
  logic [mms_pkg::SIZE_W-1:0] inner_q, cols_q;
  mms_pkg::state_e            state_q, state_d;
  logic [SA_W-1:0]            load_pos_q, load_pos_d;
  logic [K_W-1:0]             inner_pos_q, inner_pos_d;
  logic [mms_pkg::ROWS_W-1:0] row_pos_q, row_pos_d;
  logic [COL_CW-1:0]          cnt_q, cnt_d;
  logic [SA_W-1:0]            rd_addr_q, rd_addr_d;
  logic                       row_end_q, row_end_d;
  logic                       out_valid_q;
  logic [mms_pkg::COL_IDX_W-1:0]    out_col_q;
  logic signed [mms_pkg::ACC_W-1:0] out_prod_q;
  logic                       out_last_row_q, out_last_mat_q;

  // Derived values
  logic [INNER_CW-1:0] inner_eff;
  logic [COL_CW-1:0]   cols_eff;
  logic [SA_W:0]       total;
  logic [SA_W-1:0]     wr_pos, wr_next;
  logic [K_W-1:0]      k;
  logic                k_last;
  logic [SA_W-1:0]     base_addr;
  logic                col_last, row_last;
  logic                cfg_hit, in_ready, in_fire, out_load;
  mms_pkg::feed_cmd_t  feed_cmd;
  mms_pkg::cell_ctrl_t cell_ctrl;
  logic                clr_busy;

  // Cell chain wiring
  logic                             tok_valid [MAX_COLS+1];
  logic [TAG_W-1:0]                 tok_tag   [MAX_COLS+1];
  logic signed [mms_pkg::ACC_W-1:0] tok_prod  [MAX_COLS+1];
  logic signed [mms_pkg::ACC_W-1:0] acc       [MAX_COLS];
  logic signed [mms_pkg::ACC_W-1:0] acc_nxt   [MAX_COLS];

  // Clamp the sizes to at least one and at most what the store and chain hold
  always_comb begin
    if (inner_q == '0) begin
      inner_eff = INNER_CW'(1);
    end else if (32'(inner_q) > MAX_INNER) begin
      inner_eff = INNER_CW'(MAX_INNER);
    end else begin
      inner_eff = INNER_CW'(inner_q);
    end
    if (cols_q == '0) begin
      cols_eff = COL_CW'(1);
    end else if (32'(cols_q) > MAX_COLS) begin
      cols_eff = COL_CW'(MAX_COLS);
    end else begin
      cols_eff = COL_CW'(cols_q);
    end
  end

  assign total   = (SA_W + 1)'(32'(inner_eff) * 32'(cols_eff));
  assign wr_pos  = (32'(load_pos_q) >= 32'(total)) ? '0 : load_pos_q;
  assign wr_next = (32'(wr_pos) + 32'd1 >= 32'(total)) ? '0 : SA_W'(32'(wr_pos) + 32'd1);

  assign k         = (32'(inner_pos_q) >= 32'(inner_eff)) ? K_W'(32'(inner_eff) - 32'd1)
                                                          : inner_pos_q;
  assign k_last    = (32'(k) + 32'd1 >= 32'(inner_eff));
  assign base_addr = SA_W'(32'(k) * 32'(cols_eff));

  assign col_last = (32'(cnt_q) + 32'd1 == 32'(cols_eff));
  assign row_last = (32'(row_pos_q) + 32'd1 >=
                     ((rows_q == '0) ? 32'd1 : 32'(rows_q)));

  assign cfg_hit  = cfg_we_i && (cfg_idx_i == mms_pkg::REG_ROW_COUNT ||
                                 cfg_idx_i == mms_pkg::REG_INNER_SIZE ||
                                 cfg_idx_i == mms_pkg::REG_COL_COUNT);
  assign in_ready = (state_q == mms_pkg::ST_IDLE) && !clr_busy;
  assign in_fire  = in_ch.valid && in_ready;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= mms_pkg::ROWS_RESET;
      inner_q <= mms_pkg::SIZE_RESET;
      cols_q  <= mms_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mms_pkg::REG_ROW_COUNT:  rows_q  <= cfg_data_i;
        mms_pkg::REG_INNER_SIZE: inner_q <= cfg_data_i[mms_pkg::SIZE_W-1:0];
        mms_pkg::REG_COL_COUNT:  cols_q  <= cfg_data_i[mms_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: next state and controls
  always_comb begin
    state_d     = state_q;
    load_pos_d  = load_pos_q;
    inner_pos_d = inner_pos_q;
    row_pos_d   = row_pos_q;
    cnt_d       = cnt_q;
    rd_addr_d   = rd_addr_q;
    row_end_d   = row_end_q;
    out_load    = 1'b0;
    feed_cmd    = '0;
    cell_ctrl   = '0;
    case (state_q)
      mms_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.command == mms_pkg::CMD_WEIGHT) begin
            feed_cmd.wr_en = 1'b1;
            load_pos_d     = wr_next;
          end else begin
            feed_cmd.load_a = 1'b1;
            rd_addr_d       = base_addr;
            row_end_d       = k_last;
            inner_pos_d     = k_last ? '0 : K_W'(32'(k) + 32'd1);
            cnt_d           = '0;
            state_d         = mms_pkg::ST_ISSUE;
          end
        end
      end
      mms_pkg::ST_ISSUE: begin
        feed_cmd.issue = 1'b1;
        rd_addr_d      = rd_addr_q + 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (col_last) begin
          cnt_d   = '0;
          state_d = mms_pkg::ST_FLUSH;
        end
      end
      mms_pkg::ST_FLUSH: begin
        // wait for the last product to reach its cell
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == cols_eff) begin
          cnt_d   = '0;
          state_d = row_end_q ? mms_pkg::ST_DRAIN : mms_pkg::ST_IDLE;
        end
      end
      mms_pkg::ST_DRAIN: begin
        if (!out_valid_q || out_ch.ready) begin
          out_load        = 1'b1;
          cell_ctrl.shift = 1'b1;
          cnt_d           = cnt_q + 1'b1;
          if (col_last) begin
            cnt_d     = '0;
            row_pos_d = row_last ? '0 : row_pos_q + 1'b1;
            state_d   = mms_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = mms_pkg::ST_IDLE;
      end
    endcase
    // A register write restarts both streams
    if (cfg_hit) begin
      load_pos_d      = '0;
      inner_pos_d     = '0;
      row_pos_d       = '0;
      cell_ctrl.clear = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mms_pkg::ST_IDLE;
      load_pos_q  <= '0;
      inner_pos_q <= '0;
      row_pos_q   <= '0;
      cnt_q       <= '0;
      rd_addr_q   <= '0;
      row_end_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_pos_q  <= load_pos_d;
      inner_pos_q <= inner_pos_d;
      row_pos_q   <= row_pos_d;
      cnt_q       <= cnt_d;
      rd_addr_q   <= rd_addr_d;
      row_end_q   <= row_end_d;
      out_valid_q <= out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_q);
    end
  end

  // Output register: take the chain head
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_col_q      <= mms_pkg::COL_IDX_W'(cnt_q);
      out_prod_q     <= acc[0];
      out_last_row_q <= col_last;
      out_last_mat_q <= col_last && row_last;
    end
  end

  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid_q;
  assign out_ch.col_index      = out_col_q;
  assign out_ch.product_value  = out_prod_q;
  assign out_ch.last_of_row    = out_last_row_q;
  assign out_ch.last_of_matrix = out_last_mat_q;

  // Weight store and multiplier at the chain head
  mms_weight_feed #(
    .MAX_INNER     (MAX_INNER),
    .MAX_COLS      (MAX_COLS),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_feed (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (feed_cmd),
    .wr_addr_i   (wr_pos),
    .elem_i      (in_ch.element_value),
    .rd_addr_i   (rd_addr_q),
    .tag_i       (TAG_W'(cnt_q)),
    .clr_busy_o  (clr_busy),
    .tok_valid_o (tok_valid[0]),
    .tok_tag_o   (tok_tag[0]),
    .tok_prod_o  (tok_prod[0])
  );

  // Chain of accumulator cells, one per column
  for (genvar j = 0; j < MAX_COLS; j++) begin : g_cell
    if (j == MAX_COLS - 1) begin : g_tail
      assign acc_nxt[j] = '0;
    end else begin : g_mid
      assign acc_nxt[j] = acc[j+1];
    end

    mms_mac_cell #(
      .CELL_IDX (j),
      .TAG_W    (TAG_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .tok_valid_i (tok_valid[j]),
      .tok_tag_i   (tok_tag[j]),
      .tok_prod_i  (tok_prod[j]),
      .tok_valid_o (tok_valid[j+1]),
      .tok_tag_o   (tok_tag[j+1]),
      .tok_prod_o  (tok_prod[j+1]),
      .acc_next_i  (acc_nxt[j]),
      .acc_o       (acc[j])
    );
  end

`ifndef SYNTHESIS
  // Every product is caught by its own cell before the chain ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tok_valid[MAX_COLS] && tok_tag[MAX_COLS] == tok_tag[MAX_COLS]))
    else $error("product token ran off the end of the cell chain");

  // While draining, the weight feed puts no product token into the chain head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mms_pkg::ST_DRAIN |-> !tok_valid[0])
    else $error("drain started with products still in flight");

  // A new result appears only while draining
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == mms_pkg::ST_DRAIN)
    else $error("result loaded outside the drain phase");

  // End of matrix is always also end of row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_mat_q |-> out_last_row_q)
    else $error("last_of_matrix without last_of_row");

  // No item is taken while the weight store is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !in_ready)
    else $error("input accepted during store clearing");
`endif

endmodule

FILE: src/mms_mac_cell.sv
// One accumulator cell of the chain: catches the product token tagged with its
// column, passes other tokens on, and shifts its sum toward the chain head.
// Depends on mms_pkg.
module mms_mac_cell #(
  parameter int CELL_IDX = 0,
  parameter int TAG_W    = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mms_pkg::cell_ctrl_t               ctrl_i,
  input  logic                              tok_valid_i,
  input  logic [TAG_W-1:0]                  tok_tag_i,
  input  logic signed [mms_pkg::ACC_W-1:0]  tok_prod_i,
  output logic                              tok_valid_o,
  output logic [TAG_W-1:0]                  tok_tag_o,
  output logic signed [mms_pkg::ACC_W-1:0]  tok_prod_o,
  input  logic signed [mms_pkg::ACC_W-1:0]  acc_next_i,
  output logic signed [mms_pkg::ACC_W-1:0]  acc_o
);

  logic                             hit;
  logic signed [mms_pkg::ACC_W-1:0] acc_q, acc_d;
  logic                             tok_valid_q;
  logic [TAG_W-1:0]                 tok_tag_q;
  logic signed [mms_pkg::ACC_W-1:0] tok_prod_q;

  assign hit = tok_valid_i && (tok_tag_i == TAG_W'(CELL_IDX));

  // Clear, shift toward the head, or add the product meant for this column
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.shift) begin
      acc_d = acc_next_i;
    end else if (hit) begin
      acc_d = acc_q + tok_prod_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      tok_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      tok_valid_q <= tok_valid_i && !hit;
    end
  end

  // Hand the token to the next cell
  always_ff @(posedge clk_i) begin
    tok_tag_q  <= tok_tag_i;
    tok_prod_q <= tok_prod_i;
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_tag_o   = tok_tag_q;
  assign tok_prod_o  = tok_prod_q;
  assign acc_o       = acc_q;

endmodule

FILE: src/mms_weight_feed.sv
// Weight store of B with its clearing pass, and the head of the cell chain:
// reads one weight a cycle, multiplies it by the held A element, emits a token.
// Depends on mms_pkg.
module mms_weight_feed #(
  parameter  int MAX_INNER     = 16,
  parameter  int MAX_COLS      = 16,
  parameter  int ELEMENT_WIDTH = 16,
  localparam int DEPTH         = MAX_INNER * MAX_COLS,
  localparam int SA_W          = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int TAG_W         = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mms_pkg::feed_cmd_t                cmd_i,
  input  logic [SA_W-1:0]                   wr_addr_i,
  input  logic [ELEMENT_WIDTH-1:0]          elem_i,
  input  logic [SA_W-1:0]                   rd_addr_i,
  input  logic [TAG_W-1:0]                  tag_i,
  output logic                              clr_busy_o,
  output logic                              tok_valid_o,
  output logic [TAG_W-1:0]                  tok_tag_o,
  output logic signed [mms_pkg::ACC_W-1:0]  tok_prod_o
);

  localparam int PROD_W = 2 * ELEMENT_WIDTH;

  logic [ELEMENT_WIDTH-1:0]        mem_q [DEPTH];
  logic                            clr_busy_q;
  logic [SA_W-1:0]                 clr_addr_q;
  logic signed [ELEMENT_WIDTH-1:0] a_q;
  logic signed [ELEMENT_WIDTH-1:0] rd_data_q;
  logic                            rd_valid_q;
  logic [TAG_W-1:0]                rd_tag_q;
  logic signed [PROD_W-1:0]        mult;
  logic                            prod_valid_q;
  logic [TAG_W-1:0]                prod_tag_q;
  logic signed [mms_pkg::ACC_W-1:0] prod_q;

  // Sweep the store with zeros after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == SA_W'(DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Store write port and registered read port
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (cmd_i.wr_en) begin
      mem_q[wr_addr_i] <= elem_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  // Hold the A element for the whole row of products
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a) begin
      a_q <= elem_i;
    end
    rd_tag_q   <= tag_i;
    prod_tag_q <= rd_tag_q;
    prod_q     <= mms_pkg::ACC_W'(mult);
  end

  assign mult = a_q * rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q   <= 1'b0;
      prod_valid_q <= 1'b0;
    end else begin
      rd_valid_q   <= cmd_i.issue;
      prod_valid_q <= rd_valid_q;
    end
  end

  assign clr_busy_o  = clr_busy_q;
  assign tok_valid_o = prod_valid_q;
  assign tok_tag_o   = prod_tag_q;
  assign tok_prod_o  = prod_q;

endmodule
